FILE: hdl/bcc_pkg.sv
package bcc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef logic [1:0] kind_t;
  typedef logic [7:0] char_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam kind_t KIND_PAREN = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY = 2'd2;

  localparam char_t CH_OPEN_PAREN = 8'h28;
  localparam char_t CH_OPEN_SQUARE = 8'h5B;
  localparam char_t CH_OPEN_CURLY = 8'h7B;
  localparam char_t CH_CLOSE_PAREN = 8'h29;
  localparam char_t CH_CLOSE_SQUARE = 8'h5D;
  localparam char_t CH_CLOSE_CURLY = 8'h7D;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_UNCLOSED = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_SINGLE   = 3'd4
  } status_t;

  typedef struct packed {
    logic    is_open;
    logic    is_close;
    kind_t   kind;
  } char_class_t;

  typedef struct packed {
    logic    valid_res;
    status_t status;
  } result_t;

  function automatic char_class_t classify(input char_t c);
    char_class_t r;
    r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    unique case (c)
      CH_OPEN_PAREN:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
      CH_OPEN_SQUARE:  r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
      CH_OPEN_CURLY:   r = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
      CH_CLOSE_PAREN:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
      CH_CLOSE_SQUARE: r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
      CH_CLOSE_CURLY:  r = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
      default:         r = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/bcc_if.sv
interface bcc_in_if;
  import bcc_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface bcc_out_if;
  import bcc_pkg::*;

  logic    valid;
  logic    ready;
  logic    valid_res;
  status_t status;

  modport source (output valid, output valid_res, output status, input ready);
  modport sink (input valid, input valid_res, input status, output ready);
endinterface

FILE: hdl/bracket_balance_checker.sv
// The verdict for a string is registered in the result buffer once its last word is accepted.
// Throughput: one word per cycle while the result buffer is not full; the stack RAM read port
// fetches the entry below the top on each accepted word, so back-to-back pops do not stall.
// A result buffer of two entries lets input continue while a verdict waits to be taken.
// Reset is synchronous and clears the depth, the held error, the first-word flag and the buffer;
// the stack RAM is not cleared.
module bracket_balance_checker (
  input logic       clk,
  input logic       rst_n,
  bcc_in_if.sink    in_ch,
  bcc_out_if.source out_ch
);
  import bcc_pkg::*;

  logic    fire;
  logic    full;
  logic    res_vld;
  result_t res;

  assign in_ch.ready = !full;
  assign fire = in_ch.valid && !full;

  bcc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .char_code (in_ch.char_code),
    .is_last   (in_ch.is_last),
    .res_vld   (res_vld),
    .res       (res)
  );

  bcc_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_vld (res_vld),
    .res     (res),
    .full    (full),
    .out_ch  (out_ch)
  );

endmodule

FILE: hdl/bcc_stack_ram.sv
module bcc_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/bcc_core.sv
module bcc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  bcc_pkg::char_t   char_code,
  input  logic             is_last,
  output logic             res_vld,
  output bcc_pkg::result_t res
);
  import bcc_pkg::*;

  depth_t      depth_r, depth_nxt, depth_op;
  status_t     err_r, err_nxt, err_op;
  logic        first_r, first_nxt;
  kind_t       tos_r, tos_nxt, tos_op;
  kind_t       second;
  depth_t      rd_depth;
  addr_t       rd_addr;
  logic        wr_en;
  char_class_t cls;
  status_t     status;

  // The top entry lives in tos_r; the RAM keeps the entry just below it on its read port.
  bcc_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH ($bits(kind_t))
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (depth_r[ADDR_W-1:0]),
    .wr_data   (cls.kind),
    .rd_en     (fire),
    .rd_addr   (rd_addr),
    .rd_data_r (second)
  );

  always_comb begin
    cls = classify(char_code);
    depth_op = depth_r;
    err_op = err_r;
    tos_op = tos_r;
    wr_en = 1'b0;
    if (err_r == ST_OK) begin
      if (cls.is_open) begin
        if (depth_r == DEPTH_W'(STACK_DEPTH)) begin
          err_op = ST_OVERFLOW;
        end else begin
          wr_en = fire;
          depth_op = depth_r + depth_t'(1);
          tos_op = cls.kind;
        end
      end else if (cls.is_close) begin
        if (depth_r == '0 || tos_r != cls.kind) begin
          err_op = ST_MISMATCH;
        end else begin
          depth_op = depth_r - depth_t'(1);
          tos_op = second;
        end
      end
    end

    if (err_op != ST_OK) begin
      status = err_op;
    end else if (first_r) begin
      status = ST_SINGLE;
    end else if (depth_op != '0) begin
      status = ST_UNCLOSED;
    end else begin
      status = ST_OK;
    end

    rd_depth = depth_op - depth_t'(2);
    rd_addr = rd_depth[ADDR_W-1:0];

    if (is_last) begin
      depth_nxt = '0;
      err_nxt = ST_OK;
      first_nxt = 1'b1;
    end else begin
      depth_nxt = depth_op;
      err_nxt = err_op;
      first_nxt = 1'b0;
    end
    tos_nxt = tos_op;

    res_vld = fire && is_last;
    res.valid_res = (status == ST_OK);
    res.status = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      err_r <= ST_OK;
      first_r <= 1'b1;
    end else if (fire) begin
      depth_r <= depth_nxt;
      err_r <= err_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tos_r <= tos_nxt;
    end
  end

endmodule

FILE: hdl/bcc_out_buf.sv
module bcc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_vld,
  input  bcc_pkg::result_t res,
  output logic             full,
  bcc_out_if.source        out_ch
);
  import bcc_pkg::*;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;
  logic    load;

  assign load = !out_valid_r || out_ch.ready;
  assign full = skid_valid_r;

  assign out_ch.valid = out_valid_r;
  assign out_ch.valid_res = out_data_r.valid_res;
  assign out_ch.status = out_data_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load) begin
      if (skid_valid_r) begin
        out_valid_r <= 1'b1;
        skid_valid_r <= res_vld;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end else if (res_vld) begin
      skid_data_r <= res;
    end
  end

endmodule

FILE: test/bracket_balance_checker_test.sv
module bracket_balance_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    char_t ch;
    logic  last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic  drv_valid = 1'b0;
  char_t drv_char = '0;
  logic  drv_last = 1'b0;
  logic  drv_ready = 1'b0;
  logic  in_fire = 1'b0;

  bcc_in_if in_ch ();
  bcc_out_if out_ch ();

  assign in_ch.valid = drv_valid;
  assign in_ch.char_code = drv_char;
  assign in_ch.is_last = drv_last;
  assign out_ch.ready = drv_ready;

  bracket_balance_checker u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  word_t   word_q[$];
  result_t verdict_q[$];
  char_t   str_buf[$];

  kind_t   pred_stack[STACK_DEPTH];
  int      pred_depth = 0;
  status_t pred_err = ST_OK;
  bit      pred_first = 1'b1;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int words_total = 0;
  int strings_total = 0;
  int status_seen[5] = '{default: 0};

  function automatic int open_kind_of(char_t c);
    case (c)
      CH_OPEN_PAREN:  return int'(KIND_PAREN);
      CH_OPEN_SQUARE: return int'(KIND_SQUARE);
      CH_OPEN_CURLY:  return int'(KIND_CURLY);
      default:        return -1;
    endcase
  endfunction

  function automatic int close_kind_of(char_t c);
    case (c)
      CH_CLOSE_PAREN:  return int'(KIND_PAREN);
      CH_CLOSE_SQUARE: return int'(KIND_SQUARE);
      CH_CLOSE_CURLY:  return int'(KIND_CURLY);
      default:         return -1;
    endcase
  endfunction

  function automatic char_t opener(int k);
    case (k)
      int'(KIND_PAREN):  return CH_OPEN_PAREN;
      int'(KIND_SQUARE): return CH_OPEN_SQUARE;
      default:           return CH_OPEN_CURLY;
    endcase
  endfunction

  function automatic char_t closer(int k);
    case (k)
      int'(KIND_PAREN):  return CH_CLOSE_PAREN;
      int'(KIND_SQUARE): return CH_CLOSE_SQUARE;
      default:           return CH_CLOSE_CURLY;
    endcase
  endfunction

  task automatic track_word(char_t c, logic last);
    bit      was_first;
    int      ok;
    int      ck;
    status_t st;
    was_first = pred_first;
    ok = open_kind_of(c);
    ck = close_kind_of(c);
    pred_first = 1'b0;
    if (pred_err == ST_OK) begin
      if (ok >= 0) begin
        if (pred_depth >= STACK_DEPTH) begin
          pred_err = ST_OVERFLOW;
        end else begin
          pred_stack[pred_depth] = kind_t'(ok);
          pred_depth++;
        end
      end else if (ck >= 0) begin
        if (pred_depth == 0 || int'(pred_stack[pred_depth-1]) != ck) begin
          pred_err = ST_MISMATCH;
        end else begin
          pred_depth--;
        end
      end
    end
    if (last) begin
      if (pred_err != ST_OK) st = pred_err;
      else if (was_first) st = ST_SINGLE;
      else if (pred_depth != 0) st = ST_UNCLOSED;
      else st = ST_OK;
      verdict_q.push_back('{valid_res: (st == ST_OK), status: st});
      pred_depth = 0;
      pred_err = ST_OK;
      pred_first = 1'b1;
    end
  endtask

  task automatic report_error(string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("ERROR @%0d: %s", cycle_cnt, msg);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("bracket_balance_checker_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
      drv_ready <= 1'b0;
    end else begin
      drv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (!drv_valid || in_fire) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_valid <= 1'b1;
          drv_char <= word_q[0].ch;
          drv_last <= word_q[0].last;
          void'(word_q.pop_front());
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t exp;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_error($sformatf("unexpected verdict valid_res=%0b status=%0d",
                                 out_ch.valid_res, out_ch.status));
        end else begin
          exp = verdict_q.pop_front();
          status_seen[int'(exp.status)]++;
          if (out_ch.valid_res !== exp.valid_res || out_ch.status !== exp.status) begin
            report_error($sformatf("verdict exp valid_res=%0b status=%0d, got %0b/%0d",
                                   exp.valid_res, exp.status,
                                   out_ch.valid_res, out_ch.status));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) track_word(in_ch.char_code, in_ch.is_last);
    end
  end

  task automatic send_string();
    for (int i = 0; i < str_buf.size(); i++) begin
      word_q.push_back('{ch: str_buf[i], last: (i == str_buf.size() - 1)});
      words_total++;
    end
    strings_total++;
    str_buf.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(char_t'(s[i]));
    send_string();
  endtask

  task automatic add_balanced(int steps, int max_depth);
    int    open_kinds[$];
    int    k;
    char_t c;
    for (int i = 0; i < steps; i++) begin
      case ($urandom_range(2))
        0: begin
          if (open_kinds.size() < max_depth) begin
            k = $urandom_range(2);
            open_kinds.push_back(k);
            str_buf.push_back(opener(k));
          end
        end
        1: begin
          if (open_kinds.size() > 0) str_buf.push_back(closer(open_kinds.pop_back()));
        end
        default: begin
          c = char_t'($urandom_range(255));
          if (open_kind_of(c) >= 0 || close_kind_of(c) >= 0) c = 8'h2E;
          str_buf.push_back(c);
        end
      endcase
    end
    while (open_kinds.size() > 0) str_buf.push_back(closer(open_kinds.pop_back()));
    if (str_buf.size() == 0) str_buf.push_back(char_t'($urandom_range(255)));
  endtask

  task automatic add_deep(int n);
    int open_kinds[$];
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(2);
      open_kinds.push_back(k);
      str_buf.push_back(opener(k));
    end
    while (open_kinds.size() > 0) str_buf.push_back(closer(open_kinds.pop_back()));
  endtask

  task automatic random_string();
    int sel;
    int pos;
    sel = $urandom_range(99);
    if (sel < 60) begin
      add_balanced($urandom_range(1, 20), $urandom_range(1, 8));
    end else if (sel < 83) begin
      add_balanced($urandom_range(1, 16), $urandom_range(1, 6));
      pos = $urandom_range(str_buf.size());
      case ($urandom_range(2))
        0: void'(str_buf.pop_back());
        1: str_buf.insert(pos, closer($urandom_range(2)));
        default: str_buf.insert(pos, opener($urandom_range(2)));
      endcase
      if (str_buf.size() == 0) str_buf.push_back(closer($urandom_range(2)));
    end else if (sel < 99) begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(1)) str_buf.push_back(char_t'($urandom_range(255)));
        else if ($urandom_range(1)) str_buf.push_back(opener($urandom_range(2)));
        else str_buf.push_back(closer($urandom_range(2)));
      end
    end else begin
      add_deep($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4));
    end
    send_string();
  endtask

  task automatic fill_random(int target);
    int start;
    start = words_total;
    while (words_total - start < target) random_string();
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || drv_valid || verdict_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    send_text("()");
    send_text("([{}])");
    send_text("(");
    send_text(")");
    str_buf.push_back(8'h00);
    send_string();
    str_buf.push_back(CH_OPEN_PAREN);
    str_buf.push_back(8'h00);
    str_buf.push_back(CH_CLOSE_PAREN);
    send_string();
    send_text("(]");
    send_text("((");
    send_text("(]()");
    str_buf.push_back(8'hFF);
    str_buf.push_back(CH_CLOSE_CURLY);
    send_string();
    add_deep(STACK_DEPTH);
    send_string();
    add_deep(STACK_DEPTH + 1);
    send_string();
    fill_random(100);
    wait_drained();

    send_idle_pct = 53;
    recv_stall_pct = 0;
    fill_random(310);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 53;
    fill_random(310);
    wait_drained();

    send_idle_pct = 32;
    recv_stall_pct = 32;
    fill_random(310);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("Covered %0d words in %0d strings under four pacing phases and one long hold.",
             words_total, strings_total);
    $display("Verdicts ok %0d, mismatch %0d, unclosed %0d, overflow %0d, single %0d.",
             status_seen[ST_OK], status_seen[ST_MISMATCH], status_seen[ST_UNCLOSED],
             status_seen[ST_OVERFLOW], status_seen[ST_SINGLE]);
    if (err_cnt == 0) begin
      $display("bracket_balance_checker_test: clean");
    end else begin
      $display("bracket_balance_checker_test: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/bcc_pkg.sv
hdl/bcc_if.sv
hdl/bcc_stack_ram.sv
hdl/bcc_core.sv
hdl/bcc_out_buf.sv
hdl/bracket_balance_checker.sv
test/bracket_balance_checker_test.sv
